@@ design/rtc_pkg.sv @@
// Package for the seconds real-time clock register block.
// Holds the request codes, register offsets, status bit positions and the
// request and result structs. No dependencies.
package rtc_pkg;

	// Request codes carried on the op field
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Word offsets in the register window
	localparam logic [9:0] IDX_COUNTER = 10'd0;
	localparam logic [9:0] IDX_ALARM   = 10'd1;
	localparam logic [9:0] IDX_STATUS  = 10'd2;
	localparam logic [9:0] IDX_TRIM    = 10'd3;

	// Only full-word accesses are legal
	localparam logic [2:0] WORD_BYTES = 3'd4;

	// Status register bits
	localparam int ST_ALARM_FLAG = 0;
	localparam int ST_HZ_FLAG    = 1;
	localparam int ST_ALARM_EN   = 2;
	localparam int ST_HZ_EN      = 3;
	localparam logic [7:0] ST_W1C_MASK = 8'h03;

	// Trim register reset value and lock bit
	localparam logic [31:0] TRIM_RESET = 32'h0000_7FFF;
	localparam int TRIM_LOCK_BIT = 31;

	typedef struct packed {
		logic [1:0]  op;
		logic [9:0]  reg_index;
		logic [2:0]  access_bytes;
		logic [31:0] write_data;
	} rtc_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bus_error;
		logic        alarm_irq;
		logic        hz_irq;
	} rtc_rsp_t;

endpackage

@@ design/rtc_core.sv @@
// Architectural registers of the real-time clock and the single-pass logic
// that applies one request to them and forms its response.
// Depends on rtc_pkg.
module rtc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  rtc_pkg::rtc_req_t req,
	output rtc_pkg::rtc_rsp_t rsp
);
	import rtc_pkg::*;

	logic [31:0] count_q;
	logic [31:0] alarm_q;
	logic [7:0]  status_q;
	logic [31:0] trim_q;
	logic [31:0] last_q;

	logic [31:0] count_c;
	logic [31:0] alarm_c;
	logic [7:0]  status_c;
	logic [31:0] trim_c;
	logic [31:0] last_c;
	logic [7:0]  status_f;
	logic        refresh;
	logic        size_ok;
	logic [7:0]  wd8;
	logic [31:0] rd_c;
	logic        err_c;

	assign size_ok = (req.access_bytes == WORD_BYTES);
	assign wd8     = req.write_data[7:0];

	// Apply the request to the register set before the flag refresh
	always_comb begin
		count_c   = count_q;
		alarm_c   = alarm_q;
		status_c  = status_q;
		trim_c    = trim_q;
		refresh   = 1'b0;
		rd_c      = '0;
		err_c     = 1'b0;
		case (req.op)
			OP_TICK: begin
				count_c = count_q + 32'd1;
				refresh = 1'b1;
			end
			OP_WRITE: begin
				if (!size_ok) begin
					err_c = 1'b1;
				end else begin
					unique case (req.reg_index)
						IDX_COUNTER: count_c = req.write_data;
						IDX_ALARM: begin
							alarm_c = req.write_data;
							refresh = 1'b1;
						end
						IDX_STATUS: begin
							status_c = (wd8 & ~ST_W1C_MASK) | (status_q & ~wd8 & ST_W1C_MASK);
							refresh  = 1'b1;
						end
						IDX_TRIM: begin
							if (!trim_q[TRIM_LOCK_BIT]) begin
								trim_c = req.write_data;
							end
						end
						default: ;
					endcase
				end
			end
			OP_READ: begin
				if (!size_ok) begin
					err_c = 1'b1;
				end else begin
					unique case (req.reg_index)
						IDX_COUNTER: rd_c = count_q;
						IDX_ALARM:   rd_c = alarm_q;
						IDX_STATUS:  rd_c = {24'd0, status_q};
						IDX_TRIM:    rd_c = trim_q;
						default:     rd_c = '0;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Flag refresh: only when the counter has moved since it was last seen
	always_comb begin
		status_f = status_c;
		last_c   = last_q;
		if (refresh && (last_q != count_c)) begin
			if (status_c[ST_ALARM_EN] && (count_c == alarm_c)) begin
				status_f[ST_ALARM_FLAG] = 1'b1;
			end
			if (status_c[ST_HZ_EN]) begin
				status_f[ST_HZ_FLAG] = 1'b1;
			end
			last_c = count_c;
		end
	end

	assign rsp = '{read_data: rd_c, bus_error: err_c,
		alarm_irq: status_f[ST_ALARM_FLAG], hz_irq: status_f[ST_HZ_FLAG]};

	// Register update when the request commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			alarm_q  <= '0;
			status_q <= '0;
			trim_q   <= TRIM_RESET;
			last_q   <= '0;
		end else if (en) begin
			count_q  <= count_c;
			alarm_q  <= alarm_c;
			status_q <= status_f;
			trim_q   <= trim_c;
			last_q   <= last_c;
		end
	end

	// Once locked, the trim word stays locked.
	a_trim_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(trim_q[TRIM_LOCK_BIT]) |-> trim_q[TRIM_LOCK_BIT])
		else $error("trim lock bit cleared");

	// A committed tick always leaves the last seen value equal to the counter.
	a_tick_syncs_last: assert property (@(posedge clk) disable iff (!arst_n)
		(en && req.op == OP_TICK) |=> (last_q == count_q))
		else $error("last seen count out of step after tick");

	// The write-one-to-clear flags never rise without a refresh.
	a_flags_need_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !refresh) |=> ((status_q & ST_W1C_MASK) ==
			($past(status_q) & ST_W1C_MASK & ~(status_q ^ $past(status_q)))
			|| (status_q & ST_W1C_MASK & ~$past(status_q)) == 8'd0))
		else $error("status flag set without refresh");

endmodule

@@ design/rtc_register_block.sv @@
// Top level of the seconds real-time clock register block: request input
// register, response output register and the handshakes between them.
// Depends on rtc_pkg and rtc_core.
//
//   Channel   Handshake              Payload
//   request   req_valid / req_stall  op, reg_index, access_bytes, write_data
//   response  rsp_valid / rsp_stall  read_data, bus_error, alarm_irq, hz_irq
//
// A request is registered, then applied to the clock registers and its
// response registered. One request per cycle is sustained while responses
// are not stalled. The registers commit when the request leaves the input
// register, so reads always see every earlier request. Reset returns all
// registers to their reset values with both stages empty.
// A stalled response holds the input register, which then stalls requests.
module rtc_register_block (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  op,
	input  logic [9:0]  reg_index,
	input  logic [2:0]  access_bytes,
	input  logic [31:0] write_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] read_data,
	output logic        bus_error,
	output logic        alarm_irq,
	output logic        hz_irq
);
	import rtc_pkg::*;

	logic     valid_s1;
	rtc_req_t req_s1;
	logic     valid_s2;
	rtc_rsp_t rsp_s2;
	rtc_rsp_t rsp_c;
	logic     advance;

	// Stage one moves on whenever the output register is free or draining
	assign advance   = !valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= '{op: op, reg_index: reg_index,
				access_bytes: access_bytes, write_data: write_data};
		end
	end

	rtc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && advance),
		.req    (req_s1),
		.rsp    (rsp_c)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_s2 <= rsp_c;
		end
	end

	assign rsp_valid = valid_s2;
	assign read_data = rsp_s2.read_data;
	assign bus_error = rsp_s2.bus_error;
	assign alarm_irq = rsp_s2.alarm_irq;
	assign hz_irq    = rsp_s2.hz_irq;

	// Requests are only held off by a full input register.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("request stalled with empty input register");

	// A bus error response never carries read data.
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && bus_error) |-> (read_data == 32'd0))
		else $error("bus error with nonzero read data");

	// A held response keeps the input register occupied request in place.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && rsp_stall) |=> (valid_s1 && $stable(req_s1)))
		else $error("input register changed during response stall");

endmodule

@@ dv/tb_rtc_register_block.sv @@
// Self-checking testbench for rtc_register_block: a directed table, then random
// bus reads, writes and ticks under three idling mixes, checked by a predictor.
// Depends on rtc_pkg and the rtc_register_block RTL.
module tb_rtc_register_block;
	import rtc_pkg::*;

	// Op code 3 has no function in the block
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_PER_PHASE = 430;
	localparam int QUIET_LIMIT = 4000;

	// One row of the directed table; rd and err hold when fixed is set
	typedef struct packed {
		logic [1:0]  op;
		logic [9:0]  idx;
		logic [2:0]  nbytes;
		logic [31:0] data;
		logic        fixed;
		logic [31:0] rd;
		logic        err;
	} stim_row_t;

	localparam int N_ROWS = 24;
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{OP_READ,   IDX_COUNTER, WORD_BYTES, 32'h0,          1'b1, 32'h0,      1'b0},
		'{OP_READ,   IDX_ALARM,   WORD_BYTES, 32'h0,          1'b1, 32'h0,      1'b0},
		'{OP_READ,   IDX_STATUS,  WORD_BYTES, 32'h0,          1'b1, 32'h0,      1'b0},
		'{OP_READ,   IDX_TRIM,    WORD_BYTES, 32'h0,          1'b1, TRIM_RESET, 1'b0},
		'{OP_READ,   10'd1023,    WORD_BYTES, 32'h0,          1'b1, 32'h0,      1'b0},
		'{OP_READ,   IDX_TRIM,    3'd1,       32'h0,          1'b1, 32'h0,      1'b1},
		'{OP_WRITE,  IDX_COUNTER, 3'd2,       32'hFFFF_FFFF,  1'b1, 32'h0,      1'b1},
		'{OP_READ,   IDX_STATUS,  3'd3,       32'hFFFF_FFFF,  1'b1, 32'h0,      1'b1},
		'{OP_UNUSED, IDX_TRIM,    WORD_BYTES, 32'hFFFF_FFFF,  1'b1, 32'h0,      1'b0},
		'{OP_WRITE,  IDX_STATUS,  WORD_BYTES, 32'hFFFF_FFFF,  1'b0, 32'h0,      1'b0},
		'{OP_WRITE,  IDX_ALARM,   WORD_BYTES, 32'h0000_0005,  1'b0, 32'h0,      1'b0},
		'{OP_WRITE,  IDX_COUNTER, WORD_BYTES, 32'hFFFF_FFFF,  1'b0, 32'h0,      1'b0},
		'{OP_READ,   IDX_COUNTER, WORD_BYTES, 32'h0,          1'b0, 32'h0,      1'b0},
		'{OP_TICK,   10'd1023,    3'd1,       32'hFFFF_FFFF,  1'b0, 32'h0,      1'b0},
		'{OP_TICK,   IDX_COUNTER, WORD_BYTES, 32'h0,          1'b0, 32'h0,      1'b0},
		'{OP_WRITE,  IDX_COUNTER, WORD_BYTES, 32'h0000_0004,  1'b0, 32'h0,      1'b0},
		'{OP_TICK,   IDX_ALARM,   3'd2,       32'h5A5A_A5A5,  1'b0, 32'h0,      1'b0},
		'{OP_READ,   IDX_STATUS,  WORD_BYTES, 32'h0,          1'b0, 32'h0,      1'b0},
		'{OP_WRITE,  IDX_STATUS,  WORD_BYTES, 32'h0000_000F,  1'b0, 32'h0,      1'b0},
		'{OP_WRITE,  IDX_TRIM,    WORD_BYTES, 32'h1234_5678,  1'b0, 32'h0,      1'b0},
		'{OP_WRITE,  IDX_TRIM,    WORD_BYTES, 32'h8000_0000,  1'b0, 32'h0,      1'b0},
		'{OP_WRITE,  IDX_TRIM,    WORD_BYTES, 32'h7FFF_FFFF,  1'b0, 32'h0,      1'b0},
		'{OP_WRITE,  10'd1023,    WORD_BYTES, 32'hFFFF_FFFF,  1'b0, 32'h0,      1'b0},
		'{OP_READ,   IDX_TRIM,    WORD_BYTES, 32'h0,          1'b0, 32'h0,      1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  op = OP_READ;
	logic [9:0]  reg_index = '0;
	logic [2:0]  access_bytes = WORD_BYTES;
	logic [31:0] write_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [31:0] read_data;
	logic        bus_error;
	logic        alarm_irq;
	logic        hz_irq;

	// Typed-in expectation travelling with the current request
	logic        row_fixed = 1'b0;
	logic [31:0] row_rd = '0;
	logic        row_err = 1'b0;

	// Shadow of the clock registers
	logic [31:0] sec_cnt;
	logic [31:0] alarm_val;
	logic [7:0]  status_r;
	logic [31:0] trim_r;
	logic [31:0] last_cnt;

	rtc_rsp_t rsp_q[$];
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int n_sent = 0;
	int n_checked = 0;
	int fails = 0;
	int quiet = 0;
	int n_by_op[4] = '{0, 0, 0, 0};
	int n_bus_err = 0;
	int n_alarm_rsp = 0;
	int n_hz_rsp = 0;

	rtc_register_block i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.op           (op),
		.reg_index    (reg_index),
		.access_bytes (access_bytes),
		.write_data   (write_data),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.read_data    (read_data),
		.bus_error    (bus_error),
		.alarm_irq    (alarm_irq),
		.hz_irq       (hz_irq)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Flags move only when the counter has changed since the last look.
	function automatic void update_flags();
		if (last_cnt != sec_cnt) begin
			if (status_r[ST_ALARM_EN] && sec_cnt == alarm_val)
				status_r[ST_ALARM_FLAG] = 1'b1;
			if (status_r[ST_HZ_EN])
				status_r[ST_HZ_FLAG] = 1'b1;
			last_cnt = sec_cnt;
		end
	endfunction

	// Applies one request to the shadow registers and returns its response.
	function automatic rtc_rsp_t predict_rtc(logic [1:0] o, logic [9:0] idx,
			logic [2:0] nb, logic [31:0] d);
		rtc_rsp_t r;
		r = '0;
		if (o == OP_TICK) begin
			sec_cnt = sec_cnt + 32'd1;
			update_flags();
		end else if (o == OP_READ || o == OP_WRITE) begin
			if (nb != WORD_BYTES) begin
				r.bus_error = 1'b1;
			end else if (o == OP_WRITE) begin
				case (idx)
					IDX_COUNTER: sec_cnt = d;
					IDX_ALARM: begin
						alarm_val = d;
						update_flags();
					end
					IDX_STATUS: begin
						status_r = (d[7:0] & ~ST_W1C_MASK) |
							(status_r & ~d[7:0] & ST_W1C_MASK);
						update_flags();
					end
					IDX_TRIM: if (!trim_r[TRIM_LOCK_BIT]) trim_r = d;
					default: ;
				endcase
			end else begin
				case (idx)
					IDX_COUNTER: r.read_data = sec_cnt;
					IDX_ALARM:   r.read_data = alarm_val;
					IDX_STATUS:  r.read_data = {24'h0, status_r};
					IDX_TRIM:    r.read_data = trim_r;
					default:     r.read_data = '0;
				endcase
			end
		end
		r.alarm_irq = status_r[ST_ALARM_FLAG];
		r.hz_irq = status_r[ST_HZ_FLAG];
		return r;
	endfunction

	// Receiver stalls at random at the current rate.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Predicts on every accepted request, checks every accepted response,
	// and ends the run if the channels go quiet for too long.
	always @(posedge clk) begin : monitor
		rtc_rsp_t want;
		rtc_rsp_t got;
		if (!arst_n) begin
			sec_cnt = '0;
			alarm_val = '0;
			status_r = '0;
			trim_r = TRIM_RESET;
			last_cnt = '0;
		end else begin
			if (req_valid && !req_stall) begin
				want = predict_rtc(op, reg_index, access_bytes, write_data);
				if (row_fixed) begin
					want.read_data = row_rd;
					want.bus_error = row_err;
				end
				rsp_q.push_back(want);
				n_by_op[op]++;
			end
			if (rsp_valid && !rsp_stall) begin
				got = '{read_data, bus_error, alarm_irq, hz_irq};
				n_checked++;
				if (bus_error) n_bus_err++;
				if (alarm_irq) n_alarm_rsp++;
				if (hz_irq) n_hz_rsp++;
				if (rsp_q.size() == 0) begin
					$error("response with no request outstanding: read_data %h", read_data);
					fails++;
				end else begin
					want = rsp_q.pop_front();
					if (got.read_data !== want.read_data) begin
						$error("read_data expected %h actual %h", want.read_data,
							got.read_data);
						fails++;
					end
					if (got.bus_error !== want.bus_error) begin
						$error("bus_error expected %b actual %b", want.bus_error,
							got.bus_error);
						fails++;
					end
					if (got.alarm_irq !== want.alarm_irq) begin
						$error("alarm_irq expected %b actual %b", want.alarm_irq,
							got.alarm_irq);
						fails++;
					end
					if (got.hz_irq !== want.hz_irq) begin
						$error("hz_irq expected %b actual %b", want.hz_irq, got.hz_irq);
						fails++;
					end
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet == QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Presents one request, with random idle cycles ahead of it, and
	// returns at the edge where it is accepted.
	task automatic send_request(logic [1:0] o, logic [9:0] idx, logic [2:0] nb,
			logic [31:0] d, logic fx, logic [31:0] rd, logic er);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		op <= o;
		reg_index <= idx;
		access_bytes <= nb;
		write_data <= d;
		row_fixed <= fx;
		row_rd <= rd;
		row_err <= er;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		n_sent++;
	endtask

	// Holds requests back until every response is in.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (n_checked != n_sent) @(posedge clk);
	endtask

	// Random request, biased so the counter lands on the alarm and wraps.
	task automatic send_random();
		int sel;
		logic [1:0] o;
		logic [9:0] idx;
		logic [2:0] nb;
		logic [31:0] d;
		sel = $urandom_range(99);
		if (sel < 30) o = OP_TICK;
		else if (sel < 60) o = OP_READ;
		else if (sel < 96) o = OP_WRITE;
		else o = OP_UNUSED;
		idx = ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(3));
		nb = ($urandom_range(9) == 0) ? 3'($urandom_range(3, 1)) : WORD_BYTES;
		d = $urandom;
		if (o == OP_WRITE) begin
			case (idx)
				IDX_COUNTER: begin
					sel = $urandom_range(3);
					if (sel == 0) d = 32'hFFFF_FFFF - $urandom_range(2);
					else if (sel != 3) d = alarm_val - $urandom_range(3);
				end
				IDX_ALARM: if ($urandom_range(1)) d = sec_cnt + $urandom_range(3);
				IDX_STATUS: if ($urandom_range(3) != 0) d[ST_HZ_EN:ST_ALARM_EN] = 2'b11;
				IDX_TRIM: if ($urandom_range(31) != 0) d[TRIM_LOCK_BIT] = 1'b0;
				default: ;
			endcase
		end
		send_request(o, idx, nb, d, 1'b0, '0, 1'b0);
	endtask

	initial begin : stimulus
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		// Directed table: reset values, size errors, wrap, alarm hit, trim lock.
		tx_idle_pct = 8;
		rx_idle_pct = 79;
		for (int i = 0; i < N_ROWS; i++) begin
			send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].idx,
				DIRECTED_ROWS[i].nbytes, DIRECTED_ROWS[i].data,
				DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].rd, DIRECTED_ROWS[i].err);
		end
		wait_for_drain();

		// Random traffic under each idling mix, drained between mixes.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 8;  rx_idle_pct = 79; end
				1: begin tx_idle_pct = 79; rx_idle_pct = 8;  end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			repeat (RANDOM_PER_PHASE) send_random();
			wait_for_drain();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d reads, %0d writes, %0d ticks, %0d unused-op requests",
			n_by_op[OP_READ], n_by_op[OP_WRITE], n_by_op[OP_TICK], n_by_op[OP_UNUSED]);
		$display("responses: %0d checked, %0d bus errors, %0d with alarm, %0d with hz",
			n_checked, n_bus_err, n_alarm_rsp, n_hz_rsp);
		if (fails == 0 && rsp_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
